### rtl/rhls_pkg.sv
// Shared widths and constants for the RGB lightness shade block.
package rhls_pkg;

  localparam int unsigned CB   = 8;               // channel width
  localparam int unsigned SB   = 8;               // shade register width
  localparam int unsigned NCH  = 3;               // channels per pixel
  localparam int unsigned TW   = CB + 2;          // signed offset 2*(c-m)-d
  localparam int unsigned LW   = ((CB > SB) ? CB : SB) + 3;  // lightness sum
  localparam int unsigned PW   = 2 * CB + 3;      // signed product / numerator
  localparam int unsigned W    = 2 * CB + 2;      // dividend width
  localparam int unsigned Q    = CB + 1;          // quotient bits, one stage each

  localparam logic [CB-1:0]  FULL     = {CB{1'b1}};
  localparam logic [CB:0]    FULL2    = {FULL, 1'b0};
  localparam logic [SB-1:0]  SHADE_RST = SB'(51);

  typedef logic [CB-1:0] chan_t;
  typedef logic [W-1:0]  rem_t;
  typedef logic [Q-1:0]  quo_t;

endpackage

### rtl/rgb_hsl_lightness_shade.sv
// Top level: pipelined RGB to HSL lightness shade and back to RGB.
//
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  in      | in_valid_i, in_stall_o, {red,green,blue}_in_i  | sink
//  out     | out_valid_o, out_stall_i, {red,green,blue}_out_o | source
//  cfg     | cfg_we_i, cfg_data_i (shade_amount)     | sink
//
// One pixel per clock sustained while the output is not stalled; a restoring
// divider yields one quotient bit per stage for each channel.
// Reset clears the stage valid bits and loads shade_amount with 51.
// A stalled output freezes the whole pipeline; in_stall_o rises in the
// same cycle, so no transfer is lost or repeated.
module rgb_hsl_lightness_shade (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [rhls_pkg::SB-1:0]  cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [rhls_pkg::CB-1:0]  red_in_i,
  input  logic [rhls_pkg::CB-1:0]  green_in_i,
  input  logic [rhls_pkg::CB-1:0]  blue_in_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [rhls_pkg::CB-1:0]  red_out_o,
  output logic [rhls_pkg::CB-1:0]  green_out_o,
  output logic [rhls_pkg::CB-1:0]  blue_out_o
);

  localparam int unsigned CB  = rhls_pkg::CB;
  localparam int unsigned NCH = rhls_pkg::NCH;
  localparam int unsigned Q   = rhls_pkg::Q;
  localparam int unsigned W   = rhls_pkg::W;
  localparam int unsigned TW  = rhls_pkg::TW;
  localparam int unsigned LW  = rhls_pkg::LW;
  localparam int unsigned PW  = rhls_pkg::PW;

  // whole pipe advances unless the output transfer is blocked
  logic en;
  logic out_valid_q;
  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  // shade register
  logic [rhls_pkg::SB-1:0] shade_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shade_q <= rhls_pkg::SHADE_RST;
    end else if (cfg_we_i) begin
      shade_q <= cfg_data_i;
    end
  end

  // ---------------- stage 1: min, max, spread, sum ----------------
  rhls_pkg::chan_t ch_in [NCH];
  rhls_pkg::chan_t mx_d, mn_d;
  assign ch_in[0] = red_in_i;
  assign ch_in[1] = green_in_i;
  assign ch_in[2] = blue_in_i;

  always_comb begin
    mx_d = ch_in[0];
    mn_d = ch_in[0];
    for (int i = 1; i < NCH; i++) begin
      if (ch_in[i] > mx_d) mx_d = ch_in[i];
      if (ch_in[i] < mn_d) mn_d = ch_in[i];
    end
  end

  logic            v1_q;
  rhls_pkg::chan_t ch1_q [NCH];
  rhls_pkg::chan_t mn1_q, d1_q;
  logic [CB:0]     sum1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < NCH; i++) ch1_q[i] <= ch_in[i];
      mn1_q  <= mn_d;
      d1_q   <= mx_d - mn_d;
      sum1_q <= {1'b0, mx_d} + {1'b0, mn_d};
    end
  end

  // ---------------- stage 2: shaded lightness, K, offsets ----------------
  logic [CB:0]            dd_w;
  rhls_pkg::chan_t        dde_d;
  logic [LW-1:0]          lt_w;
  logic [CB:0]            l2_d;
  rhls_pkg::chan_t        k_d;
  logic signed [TW-1:0]   t_d [NCH];

  always_comb begin
    dd_w = (sum1_q <= {1'b0, rhls_pkg::FULL}) ? sum1_q : rhls_pkg::FULL2 - sum1_q;
    // grey pixel: divisor 1, offsets 0, so the result is (L2 + 1) / 2
    dde_d = (d1_q == '0) ? CB'(1) : dd_w[CB-1:0];
    if (sum1_q > {1'b0, rhls_pkg::FULL}) begin
      lt_w = LW'(sum1_q) - {shade_q, 1'b0};
      l2_d = lt_w[LW-1] ? '0 : lt_w[CB:0];
    end else begin
      lt_w = LW'(sum1_q) + {shade_q, 1'b0};
      l2_d = (lt_w > LW'(rhls_pkg::FULL2)) ? rhls_pkg::FULL2 : lt_w[CB:0];
    end
    k_d = (l2_d <= {1'b0, rhls_pkg::FULL}) ? l2_d[CB-1:0]
                                            : CB'(rhls_pkg::FULL2 - l2_d);
    for (int i = 0; i < NCH; i++) begin
      t_d[i] = $signed({1'b0, ch1_q[i] - mn1_q, 1'b0}) - $signed({2'b00, d1_q});
    end
  end

  logic                 v2_q;
  rhls_pkg::chan_t      dde2_q, k2_q;
  logic [CB:0]          l22_q;
  logic signed [TW-1:0] t2_q [NCH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dde2_q <= dde_d;
      k2_q   <= k_d;
      l22_q  <= l2_d;
      for (int i = 0; i < NCH; i++) t2_q[i] <= t_d[i];
    end
  end

  // ---------------- stage 3: products ----------------
  logic                  v3_q;
  logic [2*CB:0]         p13_q;
  logic signed [PW-1:0]  p23_q [NCH];
  rhls_pkg::chan_t       dde3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p13_q  <= l22_q * dde2_q;
      dde3_q <= dde2_q;
      for (int i = 0; i < NCH; i++) begin
        p23_q[i] <= PW'($signed({1'b0, k2_q})) * PW'(t2_q[i]);
      end
    end
  end

  // ---------------- stage 4: dividend, then one quotient bit per stage ----------------
  logic signed [PW-1:0] num_w [NCH];
  rhls_pkg::rem_t       n_d   [NCH];

  always_comb begin
    for (int i = 0; i < NCH; i++) begin
      num_w[i] = $signed({2'b00, p13_q}) + p23_q[i];
      n_d[i]   = num_w[i][PW-1] ? W'(dde3_q) : num_w[i][W-1:0] + W'(dde3_q);
    end
  end

  logic             dv_q  [Q+1];
  rhls_pkg::rem_t   rem_q [Q+1][NCH];
  rhls_pkg::quo_t   quo_q [Q+1][NCH];
  logic [CB:0]      div_q [Q+1];

  rhls_pkg::rem_t   rem_d [Q][NCH];
  rhls_pkg::quo_t   quo_d [Q][NCH];
  rhls_pkg::rem_t   sd_w  [Q];

  always_comb begin
    for (int s = 0; s < Q; s++) begin
      sd_w[s] = W'(div_q[s]) << (Q - 1 - s);
      for (int i = 0; i < NCH; i++) begin
        if (rem_q[s][i] >= sd_w[s]) begin
          rem_d[s][i] = rem_q[s][i] - sd_w[s];
          quo_d[s][i] = {quo_q[s][i][Q-2:0], 1'b1};
        end else begin
          rem_d[s][i] = rem_q[s][i];
          quo_d[s][i] = {quo_q[s][i][Q-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s <= Q; s++) dv_q[s] <= 1'b0;
    end else if (en) begin
      dv_q[0] <= v3_q;
      for (int s = 0; s < Q; s++) dv_q[s+1] <= dv_q[s];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      div_q[0] <= {dde3_q, 1'b0};
      for (int i = 0; i < NCH; i++) begin
        rem_q[0][i] <= n_d[i];
        quo_q[0][i] <= '0;
      end
      for (int s = 0; s < Q; s++) begin
        div_q[s+1] <= div_q[s];
        for (int i = 0; i < NCH; i++) begin
          rem_q[s+1][i] <= rem_d[s][i];
          quo_q[s+1][i] <= quo_d[s][i];
        end
      end
    end
  end

  // ---------------- output register with clamp ----------------
  rhls_pkg::chan_t out_q [NCH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dv_q[Q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < NCH; i++) begin
        out_q[i] <= (quo_q[Q][i] > Q'(rhls_pkg::FULL)) ? rhls_pkg::FULL
                                                       : quo_q[Q][i][CB-1:0];
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign red_out_o    = out_q[0];
  assign green_out_o  = out_q[1];
  assign blue_out_o   = out_q[2];

`ifndef NO_ASSERTIONS
  // divider never sees a zero divisor
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_q[0] |-> div_q[0] != '0)
    else $error("zero divisor entered divider");

  // restoring division leaves a remainder below the divisor
  a_rem_red: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_q[Q] |-> (rem_q[Q][0] < W'(div_q[Q])) && (rem_q[Q][1] < W'(div_q[Q]))
               && (rem_q[Q][2] < W'(div_q[Q])))
    else $error("divider remainder not reduced");

  // blocked result is held and input side is stalled
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> in_stall_o ##1 (out_valid_o && $stable(red_out_o)))
    else $error("stalled result lost");
`endif

endmodule

### test/tb_top.sv
// Testbench for the RGB lightness shade block: random and directed pixels, scoreboard check.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FULLI   = (1 << rhls_pkg::CB) - 1;
  localparam int LATENCY = 4 + rhls_pkg::Q + 1;

  typedef struct packed {
    rhls_pkg::chan_t r;
    rhls_pkg::chan_t g;
    rhls_pkg::chan_t b;
  } pixel_t;

  // Shaded-pixel scoreboard: predicts each transfer and holds the pending results.
  class shade_scoreboard;
    logic [rhls_pkg::SB-1:0] shade;
    pixel_t                  pending_px[$];
    int                      mismatches;

    function new();
      shade = rhls_pkg::SHADE_RST;
      mismatches = 0;
    endfunction

    // Exact rational HSL shade; only the final channel is rounded.
    function rhls_pkg::chan_t shade_chan(longint c, longint mn, longint d, longint dd,
                                         longint l2, longint k);
      longint num;
      longint res;
      if (d == 0 || dd == 0) begin
        res = (l2 + 1) / 2;
      end else begin
        num = l2 * dd + k * (2 * (c - mn) - d);
        if (num < 0) num = 0;
        res = (num + dd) / (2 * dd);
      end
      if (res > FULLI) res = FULLI;
      return rhls_pkg::chan_t'(res);
    endfunction

    function void note_pixel(pixel_t px);
      longint mx, mn, d, sum, dd, l2, k;
      pixel_t o;
      mx = px.r; mn = px.r;
      if (px.g > mx) mx = px.g;
      if (px.b > mx) mx = px.b;
      if (px.g < mn) mn = px.g;
      if (px.b < mn) mn = px.b;
      d   = mx - mn;
      sum = mx + mn;
      dd  = (sum < 2 * FULLI - sum) ? sum : 2 * FULLI - sum;
      // above one half: darken; exactly half or below: lighten
      l2  = (sum > FULLI) ? sum - 2 * longint'(shade) : sum + 2 * longint'(shade);
      if (l2 < 0) l2 = 0;
      if (l2 > 2 * FULLI) l2 = 2 * FULLI;
      k   = (l2 < 2 * FULLI - l2) ? l2 : 2 * FULLI - l2;
      o.r = shade_chan(px.r, mn, d, dd, l2, k);
      o.g = shade_chan(px.g, mn, d, dd, l2, k);
      o.b = shade_chan(px.b, mn, d, dd, l2, k);
      pending_px.push_back(o);
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t exp_px;
      if (pending_px.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      exp_px = pending_px.pop_front();
      if (got.r !== exp_px.r || got.g !== exp_px.g || got.b !== exp_px.b) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp r%0d g%0d b%0d got r%0d g%0d b%0d shade %0d",
                   exp_px.r, exp_px.g, exp_px.b, got.r, got.g, got.b, shade);
      end
    endfunction
  endclass

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_we_i = 1'b0;
  logic [rhls_pkg::SB-1:0] cfg_data_i = '0;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  rhls_pkg::chan_t         red_in_i = '0, green_in_i = '0, blue_in_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  rhls_pkg::chan_t         red_out_o, green_out_o, blue_out_o;

  shade_scoreboard sb = new();
  bit   calm = 1'b0;   // set during the no-idle stretch
  bit   sink_on = 1'b0;

  always #10 clk_i = ~clk_i;

  rgb_hsl_lightness_shade dut (.*);

  // Output side: random stall, check every transfer.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i)
        sb.check_pixel({red_out_o, green_out_o, blue_out_o});
      out_stall_i <= sink_on && !calm && ($urandom_range(99) < 23);
    end
  end

  // Send one pixel; hold it until the block takes the transfer.
  // Valid stays high between back-to-back pixels and drops only while idling.
  task automatic send_pixel(pixel_t px);
    while (!calm && $urandom_range(99) < 23) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    red_in_i   <= px.r;
    green_in_i <= px.g;
    blue_in_i  <= px.b;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_pixel(px);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending_px.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 2) @(posedge clk_i);
  endtask

  // Config only while idle.
  task automatic write_shade(logic [rhls_pkg::SB-1:0] v);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    sb.shade   = v;
  endtask

  task automatic random_pixels(int n);
    pixel_t px;
    repeat (n) begin
      px = pixel_t'(24'($urandom));
      // some greys and near-half pixels to hit the special cases
      case ($urandom_range(7))
        0: begin px.g = px.r; px.b = px.r; end
        1: begin px.r = 8'd127; px.g = 8'd128; end
        default: ;
      endcase
      send_pixel(px);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    sink_on = 1'b1;
    // Directed: extremes, greys, half lightness, pure hues, with reset shade.
    send_pixel({8'd0, 8'd0, 8'd0});
    send_pixel({8'd255, 8'd255, 8'd255});
    send_pixel({8'd128, 8'd128, 8'd128});
    send_pixel({8'd127, 8'd127, 8'd127});
    send_pixel({8'd255, 8'd0, 8'd0});
    send_pixel({8'd0, 8'd255, 8'd0});
    send_pixel({8'd0, 8'd0, 8'd255});
    send_pixel({8'd255, 8'd255, 8'd0});
    send_pixel({8'd255, 8'd0, 8'd128});
    send_pixel({8'd10, 8'd200, 8'd245});
    send_pixel({8'd170, 8'd85, 8'd85});
    send_pixel({8'd1, 8'd254, 8'd100});
    write_shade(8'd255);
    send_pixel({8'd0, 8'd0, 8'd0});
    send_pixel({8'd255, 8'd255, 8'd255});
    send_pixel({8'd200, 8'd30, 8'd90});
    send_pixel({8'd127, 8'd128, 8'd0});
    write_shade(8'd0);
    send_pixel({8'd255, 8'd0, 8'd0});
    send_pixel({8'd33, 8'd66, 8'd99});
    random_pixels(150);
    write_shade(8'd255);
    random_pixels(150);
    write_shade(rhls_pkg::SHADE_RST);
    calm = 1'b1;
    random_pixels(150);
    calm = 1'b0;
    write_shade(8'd1);
    random_pixels(100);
    write_shade(8'($urandom));
    random_pixels(180);
    drain();
    if (sb.mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #2ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule
